[hw/rtl/msdt_pkg.sv]
// Package with the constants, month tables and stage types of the date and time converter.
`default_nettype none

package msdt_pkg;

    localparam int unsigned MS_W = 49;

    localparam logic [MS_W-1:0] LAST_MS = 49'd315537897599999;

    // Divisors after the power-of-two factors have been shifted out.
    localparam logic [16:0] DAY_UNITS  = 17'd84375;
    localparam logic [14:0] HOUR_UNITS = 15'd28125;
    localparam logic [10:0] MIN_UNITS  = 11'd1875;
    localparam logic [6:0]  SEC_UNITS  = 7'd125;

    localparam logic [17:0] DAYS_400 = 18'd146097;
    localparam logic [10:0] DAYS_4   = 11'd1461;

    localparam logic [17:0] CENT_START [4] = '{18'd0, 18'd36524, 18'd73048, 18'd109572};
    localparam logic [10:0] YEAR_START [4] = '{11'd0, 11'd365, 11'd730, 11'd1095};

    localparam logic [8:0] MONTH_START_COMMON [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [8:0] MONTH_START_LEAP [13] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    typedef struct packed {
        logic        err;
        logic [9:0]  lo;
        logic [16:0] drem;
        logic [23:0] dbits;
    } dv_t;

    typedef struct packed {
        logic        err;
        logic [21:0] days;
        logic [26:0] tod;
    } dt_t;

    typedef struct packed {
        logic        err;
        logic [4:0]  n400;
        logic [17:0] r400;
        logic [4:0]  hour;
        logic [21:0] tod_h;
        logic [2:0]  weekday;
    } c400_t;

    typedef struct packed {
        logic        err;
        logic [4:0]  n400;
        logic [1:0]  cent;
        logic [15:0] r100;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] tod_m;
        logic [2:0]  weekday;
    } c100_t;

    typedef struct packed {
        logic        err;
        logic [4:0]  n400;
        logic [1:0]  cent;
        logic [4:0]  n4;
        logic [10:0] r4;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  milli;
        logic [2:0]  weekday;
    } c4_t;

    typedef struct packed {
        logic        err;
        logic [13:0] year;
        logic [8:0]  doy;
        logic        leap;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  milli;
        logic [2:0]  weekday;
    } yr_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  milli;
        logic [2:0]  weekday;
        logic        range_error;
    } out_t;

endpackage

`default_nettype wire

[hw/rtl/ms_count_to_civil_date_time.sv]
// Pipelined conversion of a millisecond count into a Gregorian date and time of day.
//
// Channel | Ports                                   | Transfer
// input   | s_valid, s_ready, s_ms_count            | s_valid and s_ready high at aclk
// result  | m_valid, m_ready, m_year .. m_range_error | m_valid and m_ready high at aclk
//
// One item enters per cycle while s_ready is high; its result passes through nine registers:
// input, three day-count division steps, the 400-, 100-, 4- and 1-year cycles (which also
// split out the clock fields), and the month lookup.
// A synchronous low aresetn clears every stage valid bit; data registers are not reset.
// A stage holds while the one after it is full and not moving, so bubbles close up and
// s_ready stays high while any stage is empty.
`default_nettype none

module ms_count_to_civil_date_time (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [msdt_pkg::MS_W-1:0] s_ms_count,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [13:0]                    m_year,
    output logic [3:0]                     m_month,
    output logic [4:0]                     m_day_of_month,
    output logic [4:0]                     m_hour,
    output logic [5:0]                     m_minute,
    output logic [5:0]                     m_second,
    output logic [9:0]                     m_millisecond,
    output logic [2:0]                     m_weekday,
    output logic                           m_range_error
);

    localparam int NSTAGE = 9;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] rdy;

    logic [msdt_pkg::MS_W-1:0] ms_reg;
    msdt_pkg::dv_t   dv1_reg, dv1_next;
    msdt_pkg::dv_t   dv2_reg, dv2_next;
    msdt_pkg::dt_t   dt_reg, dt_next;
    msdt_pkg::c400_t c400_reg, c400_next;
    msdt_pkg::c100_t c100_reg, c100_next;
    msdt_pkg::c4_t   c4_reg, c4_next;
    msdt_pkg::yr_t   yr_reg, yr_next;
    msdt_pkg::out_t  out_reg, out_next;

    // Eight restoring steps of the division by the day length in 1024 ms units.
    function automatic msdt_pkg::dv_t div_day8(msdt_pkg::dv_t x);
        msdt_pkg::dv_t y;
        logic [17:0]   t;
        y = x;
        for (int k = 0; k < 8; k++) begin
            t = {y.drem, y.dbits[23]};
            y.dbits = {y.dbits[22:0], 1'b0};
            if (t >= {1'b0, msdt_pkg::DAY_UNITS}) begin
                y.drem = 17'(t - {1'b0, msdt_pkg::DAY_UNITS});
                y.dbits[0] = 1'b1;
            end else begin
                y.drem = t[16:0];
            end
        end
        return y;
    endfunction

    always_comb begin
        rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        valid_next[0] = rdy[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < NSTAGE; i++) begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        msdt_pkg::dv_t d;
        logic [38:0]   q0;
        logic          err;
        err = ms_reg > msdt_pkg::LAST_MS;
        q0 = err ? 39'd0 : ms_reg[48:10];
        d.err = err;
        d.lo = err ? 10'd0 : ms_reg[9:0];
        d.drem = {2'b00, q0[38:24]};
        d.dbits = q0[23:0];
        dv1_next = div_day8(d);
    end

    assign dv2_next = div_day8(dv1_reg);

    always_comb begin
        msdt_pkg::dv_t d;
        d = div_day8(dv2_reg);
        dt_next.err = d.err;
        dt_next.days = d.dbits[21:0];
        dt_next.tod = {d.drem, d.lo};
    end

    always_comb begin
        logic [17:0] r18;
        logic [18:0] t19;
        logic [4:0]  q5;
        logic [19:0] v20;
        logic [14:0] rh;
        logic [15:0] t16;
        logic [4:0]  qh;
        logic [23:0] d1;
        logic [5:0]  sum6;
        logic [3:0]  f4;
        logic [2:0]  g3;
        r18 = {1'b0, dt_reg.days[21:5]};
        q5 = '0;
        for (int k = 0; k < 5; k++) begin
            t19 = {r18, dt_reg.days[4-k]};
            if (t19 >= {1'b0, msdt_pkg::DAYS_400}) begin
                r18 = 18'(t19 - {1'b0, msdt_pkg::DAYS_400});
                q5 = {q5[3:0], 1'b1};
            end else begin
                r18 = t19[17:0];
                q5 = {q5[3:0], 1'b0};
            end
        end
        v20 = dt_reg.tod[26:7];
        rh = v20[19:5];
        qh = '0;
        for (int k = 0; k < 5; k++) begin
            t16 = {rh, v20[4-k]};
            if (t16 >= {1'b0, msdt_pkg::HOUR_UNITS}) begin
                rh = 15'(t16 - {1'b0, msdt_pkg::HOUR_UNITS});
                qh = {qh[3:0], 1'b1};
            end else begin
                rh = t16[14:0];
                qh = {qh[3:0], 1'b0};
            end
        end
        // Eight is one modulo seven, so octal digits are summed and folded.
        d1 = 24'(dt_reg.days) + 24'd1;
        sum6 = '0;
        for (int k = 0; k < 8; k++) begin
            sum6 = sum6 + 6'(d1[3*k +: 3]);
        end
        f4 = 4'(sum6[5:3]) + 4'(sum6[2:0]);
        g3 = 3'(f4[3]) + f4[2:0];
        c400_next.err = dt_reg.err;
        c400_next.n400 = q5;
        c400_next.r400 = r18;
        c400_next.hour = qh;
        c400_next.tod_h = {rh, dt_reg.tod[6:0]};
        c400_next.weekday = (g3 == 3'd7) ? 3'd0 : g3;
    end

    always_comb begin
        logic [1:0]  cent;
        logic [16:0] v17;
        logic [10:0] rm;
        logic [11:0] t12;
        logic [5:0]  qm;
        cent = '0;
        for (int k = 1; k < 4; k++) begin
            if (c400_reg.r400 >= msdt_pkg::CENT_START[k]) begin
                cent = 2'(k);
            end
        end
        v17 = c400_reg.tod_h[21:5];
        rm = v17[16:6];
        qm = '0;
        for (int k = 0; k < 6; k++) begin
            t12 = {rm, v17[5-k]};
            if (t12 >= {1'b0, msdt_pkg::MIN_UNITS}) begin
                rm = 11'(t12 - {1'b0, msdt_pkg::MIN_UNITS});
                qm = {qm[4:0], 1'b1};
            end else begin
                rm = t12[10:0];
                qm = {qm[4:0], 1'b0};
            end
        end
        c100_next.err = c400_reg.err;
        c100_next.n400 = c400_reg.n400;
        c100_next.cent = cent;
        c100_next.r100 = 16'(c400_reg.r400 - msdt_pkg::CENT_START[cent]);
        c100_next.hour = c400_reg.hour;
        c100_next.minute = qm;
        c100_next.tod_m = {rm, c400_reg.tod_h[4:0]};
        c100_next.weekday = c400_reg.weekday;
    end

    always_comb begin
        logic [10:0] r4;
        logic [11:0] t12;
        logic [4:0]  q4;
        logic [12:0] v13;
        logic [6:0]  rs;
        logic [7:0]  t8;
        logic [5:0]  qs;
        r4 = c100_reg.r100[15:5];
        q4 = '0;
        for (int k = 0; k < 5; k++) begin
            t12 = {r4, c100_reg.r100[4-k]};
            if (t12 >= {1'b0, msdt_pkg::DAYS_4}) begin
                r4 = 11'(t12 - {1'b0, msdt_pkg::DAYS_4});
                q4 = {q4[3:0], 1'b1};
            end else begin
                r4 = t12[10:0];
                q4 = {q4[3:0], 1'b0};
            end
        end
        v13 = c100_reg.tod_m[15:3];
        rs = v13[12:6];
        qs = '0;
        for (int k = 0; k < 6; k++) begin
            t8 = {rs, v13[5-k]};
            if (t8 >= {1'b0, msdt_pkg::SEC_UNITS}) begin
                rs = 7'(t8 - {1'b0, msdt_pkg::SEC_UNITS});
                qs = {qs[4:0], 1'b1};
            end else begin
                rs = t8[6:0];
                qs = {qs[4:0], 1'b0};
            end
        end
        c4_next.err = c100_reg.err;
        c4_next.n400 = c100_reg.n400;
        c4_next.cent = c100_reg.cent;
        c4_next.n4 = q4;
        c4_next.r4 = r4;
        c4_next.hour = c100_reg.hour;
        c4_next.minute = c100_reg.minute;
        c4_next.second = qs;
        c4_next.milli = {rs, c100_reg.tod_m[2:0]};
        c4_next.weekday = c100_reg.weekday;
    end

    always_comb begin
        logic [1:0] y1;
        y1 = '0;
        for (int k = 1; k < 4; k++) begin
            if (c4_reg.r4 >= msdt_pkg::YEAR_START[k]) begin
                y1 = 2'(k);
            end
        end
        yr_next.err = c4_reg.err;
        yr_next.year = 14'(c4_reg.n400) * 14'd400 + 14'(c4_reg.cent) * 14'd100
                     + 14'(c4_reg.n4) * 14'd4 + 14'(y1) + 14'd1;
        yr_next.doy = 9'(c4_reg.r4 - msdt_pkg::YEAR_START[y1]);
        yr_next.leap = (y1 == 2'd3) && ((c4_reg.n4 != 5'd24) || (c4_reg.cent == 2'd3));
        yr_next.hour = c4_reg.hour;
        yr_next.minute = c4_reg.minute;
        yr_next.second = c4_reg.second;
        yr_next.milli = c4_reg.milli;
        yr_next.weekday = c4_reg.weekday;
    end

    always_comb begin
        logic [8:0] tab [13];
        logic [3:0] cnt;
        for (int k = 0; k < 13; k++) begin
            tab[k] = yr_reg.leap ? msdt_pkg::MONTH_START_LEAP[k]
                                 : msdt_pkg::MONTH_START_COMMON[k];
        end
        cnt = '0;
        for (int k = 1; k < 12; k++) begin
            if (tab[k] <= yr_reg.doy) begin
                cnt = cnt + 4'd1;
            end
        end
        if (yr_reg.err) begin
            out_next = '0;
            out_next.range_error = 1'b1;
        end else begin
            out_next.year = yr_reg.year;
            out_next.month = cnt + 4'd1;
            out_next.day = 5'(yr_reg.doy - tab[cnt] + 9'd1);
            out_next.hour = yr_reg.hour;
            out_next.minute = yr_reg.minute;
            out_next.second = yr_reg.second;
            out_next.milli = yr_reg.milli;
            out_next.weekday = yr_reg.weekday;
            out_next.range_error = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            ms_reg <= s_ms_count;
        end
        if (rdy[1]) begin
            dv1_reg <= dv1_next;
        end
        if (rdy[2]) begin
            dv2_reg <= dv2_next;
        end
        if (rdy[3]) begin
            dt_reg <= dt_next;
        end
        if (rdy[4]) begin
            c400_reg <= c400_next;
        end
        if (rdy[5]) begin
            c100_reg <= c100_next;
        end
        if (rdy[6]) begin
            c4_reg <= c4_next;
        end
        if (rdy[7]) begin
            yr_reg <= yr_next;
        end
        if (rdy[8]) begin
            out_reg <= out_next;
        end
    end

    assign s_ready        = rdy[0];
    assign m_valid        = valid_reg[NSTAGE-1];
    assign m_year         = out_reg.year;
    assign m_month        = out_reg.month;
    assign m_day_of_month = out_reg.day;
    assign m_hour         = out_reg.hour;
    assign m_minute       = out_reg.minute;
    assign m_second       = out_reg.second;
    assign m_millisecond  = out_reg.milli;
    assign m_weekday      = out_reg.weekday;
    assign m_range_error  = out_reg.range_error;

endmodule

`default_nettype wire

[hw/rtl/msdt_checker.sv]
// Port checker for the date and time converter and its bind to the top level.
`default_nettype none

module msdt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [13:0] m_year,
    input wire logic [3:0]  m_month,
    input wire logic [4:0]  m_day_of_month,
    input wire logic [4:0]  m_hour,
    input wire logic [5:0]  m_minute,
    input wire logic [5:0]  m_second,
    input wire logic [9:0]  m_millisecond,
    input wire logic [2:0]  m_weekday,
    input wire logic        m_range_error
);

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_year == 14'd0 && m_month == 4'd0
            && m_day_of_month == 5'd0 && m_hour == 5'd0 && m_minute == 6'd0
            && m_second == 6'd0 && m_millisecond == 10'd0 && m_weekday == 3'd0)
        else $error("range error result carries nonzero fields");

    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_range_error |-> m_year != 14'd0 && m_year <= 14'd9999
            && m_month != 4'd0 && m_month <= 4'd12 && m_day_of_month != 5'd0
            && m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59
            && m_millisecond <= 10'd999 && m_weekday <= 3'd6)
        else $error("result field out of its range");

    a_month_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_range_error && (m_month == 4'd4 || m_month == 4'd6
            || m_month == 4'd9 || m_month == 4'd11 || m_month == 4'd2)
            |-> m_day_of_month <= 5'd30 && (m_month != 4'd2 || m_day_of_month <= 5'd29))
        else $error("day beyond the length of its month");

    a_feb29: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_range_error && m_month == 4'd2 && m_day_of_month == 5'd29
            |-> m_year[1:0] == 2'd0)
        else $error("February 29 in a year not divisible by four");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_year) && $stable(m_month)
            && $stable(m_day_of_month) && $stable(m_millisecond) && $stable(m_range_error))
        else $error("stalled result changed");

endmodule

bind ms_count_to_civil_date_time msdt_checker u_msdt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_year         (m_year),
    .m_month        (m_month),
    .m_day_of_month (m_day_of_month),
    .m_hour         (m_hour),
    .m_minute       (m_minute),
    .m_second       (m_second),
    .m_millisecond  (m_millisecond),
    .m_weekday      (m_weekday),
    .m_range_error  (m_range_error)
);

`default_nettype wire
